// ===== rtl/core/cpu_util_pkg.sv =====
// Shared types and constants for the CPU busy-share block.
`timescale 1ns / 1ps
package cpu_util_pkg;

	localparam int unsigned ROW_W      = 6;
	localparam int unsigned VALUE_W    = 64;
	localparam int unsigned BUSY_W     = 15;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned COUNT_W    = 4;

	localparam logic [COUNT_W-1:0] SUM_COLUMNS = 4'd8;
	localparam logic [COUNT_W-1:0] IDLE_COL_A  = 4'd3;
	localparam logic [COUNT_W-1:0] IDLE_COL_B  = 4'd4;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd15;

	// quotient bits produced by the divider, one per step
	localparam int unsigned DIV_STEPS = BUSY_W;
	localparam logic [COUNT_W-1:0] DIV_LAST = COUNT_W'(DIV_STEPS - 1);

	localparam logic [STATUS_W-1:0] ST_VALID      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FIRST_READ = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_ELAPSED = 2'd2;

	typedef struct packed {
		logic accept;    // input request taken this cycle
		logic look;      // read and update per-row store
		logic delta;     // form total and idle deltas
		logic scale;     // scale numerator, load divider
		logic div_step;  // one restoring divide step
		logic load_out;  // move result into output register
	} cmd_t;

	typedef struct packed {
		logic row_ok;
		logic div_done;
	} sts_t;

endpackage

// ===== rtl/core/cpu_util_ctrl.sv =====
// Sequencer for the CPU busy-share block: handshakes and step order.
`timescale 1ns / 1ps
module cpu_util_ctrl import cpu_util_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LOOK   = 6'b000010,
		S_DELTA  = 6'b000100,
		S_SCALE  = 6'b001000,
		S_DIV    = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && in_last) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.look = sts.row_ok;
				state_d  = sts.row_ok ? S_DELTA : S_IDLE;
			end
			S_DELTA: begin
				cmd.delta = 1'b1;
				state_d   = S_SCALE;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/cpu_util_dp.sv =====
// Datapath: column sums, per-row sample store, deltas and serial divider.
`timescale 1ns / 1ps
module cpu_util_dp import cpu_util_pkg::*; #(
	parameter int unsigned NUM_ROWS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [ROW_W-1:0]    core_index,
	input  logic [VALUE_W-1:0]  column_value,
	input  logic                last_in_row,
	output logic [ROW_W-1:0]    row_index,
	output logic [BUSY_W-1:0]   busy_percent,
	output logic [STATUS_W-1:0] status
);

	localparam int unsigned AW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int unsigned CW = (AW > ROW_W) ? AW + 1 : ROW_W + 1;
	localparam int unsigned NW = VALUE_W + BUSY_W;

	logic [COUNT_W-1:0] col_cnt_q;
	logic [VALUE_W-1:0] total_acc_q, idle_acc_q;
	logic [VALUE_W-1:0] total_new, idle_new;
	logic [VALUE_W-1:0] total_q, idle_q;
	logic [ROW_W-1:0]   row_q;
	logic [AW-1:0]      addr;

	logic [VALUE_W-1:0] prev_total_mem [NUM_ROWS];
	logic [VALUE_W-1:0] prev_idle_mem  [NUM_ROWS];
	logic [VALUE_W-1:0] prev_total_rd_q, prev_idle_rd_q;
	logic [NUM_ROWS-1:0] seen_q;
	logic               first_q, zero_q, over_q;

	logic [VALUE_W-1:0] d_total_q, d_idle_q;
	logic [VALUE_W-1:0] num;
	logic [NW-1:0]      scaled;
	logic [VALUE_W-1:0] rem_q;
	logic [BUSY_W-1:0]  quo_q;
	logic [VALUE_W:0]   cand, diff;
	logic               take;
	logic [COUNT_W-1:0] step_q;

	logic [ROW_W-1:0]    row_out_q;
	logic [BUSY_W-1:0]   busy_out_q;
	logic [STATUS_W-1:0] status_out_q;

	// running sums including the column arriving now
	always_comb begin
		total_new = total_acc_q;
		idle_new  = idle_acc_q;
		if (col_cnt_q < SUM_COLUMNS) begin
			total_new = total_acc_q + column_value;
		end
		if (col_cnt_q == IDLE_COL_A || col_cnt_q == IDLE_COL_B) begin
			idle_new = idle_acc_q + column_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q   <= '0;
			total_acc_q <= '0;
			idle_acc_q  <= '0;
		end else if (cmd.accept) begin
			if (last_in_row) begin
				col_cnt_q   <= '0;
				total_acc_q <= '0;
				idle_acc_q  <= '0;
			end else begin
				total_acc_q <= total_new;
				idle_acc_q  <= idle_new;
				if (col_cnt_q != COUNT_MAX) begin
					col_cnt_q <= col_cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && last_in_row) begin
			total_q <= total_new;
			idle_q  <= idle_new;
			row_q   <= core_index;
		end
	end

	assign addr = AW'(row_q);

	// per-row store: read old sample, write new one in the same cycle
	always_ff @(posedge clk) begin
		if (cmd.look) begin
			prev_total_rd_q      <= prev_total_mem[addr];
			prev_idle_rd_q       <= prev_idle_mem[addr];
			prev_total_mem[addr] <= total_q;
			prev_idle_mem[addr]  <= idle_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (cmd.look) begin
			seen_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			first_q <= !seen_q[addr];
		end
		if (cmd.delta) begin
			d_total_q <= total_q - prev_total_rd_q;
			d_idle_q  <= idle_q - prev_idle_rd_q;
		end
	end

	// num * 25600 as (num * 100) << 8, built from shifts
	assign num    = d_total_q - d_idle_q;
	assign scaled = (NW'(num) << 14) + (NW'(num) << 13) + (NW'(num) << 10);

	// restoring divide; the upper part of the product is already below d_total
	assign cand = {rem_q, quo_q[BUSY_W-1]};
	assign diff = cand - {1'b0, d_total_q};
	assign take = (cand >= {1'b0, d_total_q});

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			zero_q <= (d_total_q == '0);
			over_q <= (d_idle_q > d_total_q);
			rem_q  <= scaled[NW-1:BUSY_W];
			quo_q  <= scaled[BUSY_W-1:0];
			step_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= take ? diff[VALUE_W-1:0] : cand[VALUE_W-1:0];
			quo_q  <= {quo_q[BUSY_W-2:0], take};
			step_q <= step_q + 1'b1;
		end
	end

	assign sts = '{
		row_ok:   (CW'(row_q) < CW'(NUM_ROWS)),
		div_done: (step_q == DIV_LAST)
	};

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			row_out_q <= row_q;
			if (first_q) begin
				busy_out_q   <= '0;
				status_out_q <= ST_FIRST_READ;
			end else if (zero_q) begin
				busy_out_q   <= '0;
				status_out_q <= ST_NO_ELAPSED;
			end else if (over_q) begin
				busy_out_q   <= '0;
				status_out_q <= ST_VALID;
			end else begin
				busy_out_q   <= quo_q;
				status_out_q <= ST_VALID;
			end
		end
	end

	assign row_index    = row_out_q;
	assign busy_percent = busy_out_q;
	assign status       = status_out_q;

endmodule

// ===== rtl/core/cpu_utilization_from_tick_counters_top.sv =====
// Top level of the CPU busy-share block from cumulative tick counters.
//
// Input stream: one request per counter column of a core row. s_axis_tdata
// carries the row number and the cumulative tick count, s_axis_tlast marks
// the final column. Columns 0..7 are summed as total, columns 3 and 4 as idle.
// A non-closing column is taken without leaving idle. A closing column starts a
// sequence: per-row store read and update, delta, scale, a 15-step restoring
// divide (one quotient bit per cycle), then the output load, which waits while
// the output register is still occupied; m_axis_tvalid is registered from that
// load, and s_axis_tready is low until the sequence ends.
// A row number not below NUM_ROWS gives no result; the row check ends the sequence.
// Output stream: one request per closing column with the row number and busy
// share in unsigned Q7.8 percent; m_axis_tuser gives the status (valid, first
// reading, no elapsed time). The output register holds a result while the
// receiver stalls; a following row is still summed, and its closing result
// waits in the sequencer until the output register is free.
// Reset clears the column count, sums and seen flags; every row starts over
// with a first-reading result.
`timescale 1ns / 1ps
module cpu_utilization_from_tick_counters_top import cpu_util_pkg::*; #(
	parameter int unsigned NUM_ROWS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // core_index[5:0], column_value[69:6], zero pad
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // row_index[5:0], busy_percent[20:6], zero pad
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	cmd_t cmd;
	sts_t sts;

	logic [ROW_W-1:0]    row_index;
	logic [BUSY_W-1:0]   busy_percent;
	logic [STATUS_W-1:0] status;

	cpu_util_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_last   (s_axis_tlast),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cpu_util_dp #(
		.NUM_ROWS (NUM_ROWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.core_index   (s_axis_tdata[5:0]),
		.column_value (s_axis_tdata[69:6]),
		.last_in_row  (s_axis_tlast),
		.row_index    (row_index),
		.busy_percent (busy_percent),
		.status       (status)
	);

	assign m_axis_tdata = {3'b000, busy_percent, row_index};
	assign m_axis_tuser = status;

endmodule
